>>> sv/erf_pkg.sv
package erf_pkg;

	// Default line length of the store, handed down from the top level.
	localparam int DEF_MAX_WIDTH = 1024;

	// Depth of the item queue between front and back.
	localparam int QUEUE_DEPTH = 4;

	// Field widths fixed by the interface.
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;
	localparam int ROW_W      = 12;
	localparam int OUT_COL_W  = 10;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_DATA_W = HEIGHT_REG_W;
	localparam int CFG_IDX_W  = 1;

	// Register reset values and limits.
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd1024;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = 13'd4096;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	// Offset added to the diagonal difference.
	localparam logic [CHAN_W+1:0] EMB_OFFSET = 10'd128;

	// Classification of one item, decided in the front.
	typedef struct packed {
		logic emb;     // item completes an interior result
		logic border;  // item passes through as itself
	} flags_t;

	localparam int FLAGS_W = $bits(flags_t);

	// One channel of the emboss: now - old + 128, clamped to 0..255.
	function automatic logic [CHAN_W-1:0] emb_chan(input logic [CHAN_W-1:0] now,
	                                              input logic [CHAN_W-1:0] old);
		logic [CHAN_W+1:0] v;
		v = {2'b00, now} - {2'b00, old} + EMB_OFFSET;
		if (v[CHAN_W+1]) begin
			emb_chan = '0;
		end else if (v[CHAN_W]) begin
			emb_chan = '1;
		end else begin
			emb_chan = v[CHAN_W-1:0];
		end
	endfunction

endpackage

>>> sv/erf_ram.sv
module erf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Registered read; a read at the written address returns the old word.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> sv/erf_fifo.sv
module erf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int NW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [NW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == NW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = entry_q[rptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wdata;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/erf_front.sv
module erf_front import erf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int WW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
	                    $clog2(MAX_WIDTH + 1) : WIDTH_REG_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  accept,
	output logic [ROW_W-1:0]      row,
	output logic [CW-1:0]         col,
	output flags_t                flags
);

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [ROW_W-1:0]        row_q;
	logic [CW-1:0]           col_q;
	logic [WW-1:0]           width_ext;
	logic [WW-1:0]           eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;
	logic [WW-1:0]           col_inc;
	logic [HEIGHT_REG_W-1:0] row_inc;
	logic                    col_end;
	logic                    row_end;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size, clamped to what the store and row field hold.
	always_comb begin
		width_ext = WW'(width_q);
		if (width_ext == '0) begin
			eff_w = WW'(1);
		end else if (width_ext > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = width_ext;
		end
		if (height_q == '0) begin
			eff_h = HEIGHT_REG_W'(1);
		end else if (height_q > HEIGHT_LIMIT) begin
			eff_h = HEIGHT_LIMIT;
		end else begin
			eff_h = height_q;
		end
	end

	// Classify the current position.
	assign col_inc = WW'(col_q) + WW'(1);
	assign row_inc = HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1);
	assign col_end = (col_inc >= eff_w);
	assign row_end = (row_inc >= eff_h);

	assign flags.emb    = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));
	assign flags.border = (row_q == '0) || (col_q == '0) || row_end || col_end;
	assign row = row_q;
	assign col = col_q;

	// Raster position of the next transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

endmodule

>>> sv/erf_back.sv
module erf_back import erf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int AW = $clog2(2 * MAX_WIDTH)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Item queue side.
	input  logic                 q_empty,
	output logic                 q_pop,
	input  logic [PIX_W-1:0]     q_pix,
	input  logic [ROW_W-1:0]     q_row,
	input  logic [CW-1:0]        q_col,
	input  flags_t               q_flags,
	// Result side.
	output logic                 empty,
	input  logic                 pop,
	output logic [PIX_W-1:0]     res_pix,
	output logic [ROW_W-1:0]     res_row,
	output logic [OUT_COL_W-1:0] res_col,
	output logic                 res_last
);

	logic                 valid_s1;
	logic                 phase_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [CW-1:0]        col_s1;
	flags_t               flags_s1;
	logic [PIX_W-1:0]     old_word;
	logic [PIX_W-1:0]     delay1_q;
	logic [PIX_W-1:0]     delay2_q;
	logic [AW-1:0]        addr;
	logic [PIX_W-1:0]     emb_word;
	logic                 out_valid_q;
	logic [PIX_W-1:0]     out_pix_q;
	logic [ROW_W-1:0]     out_row_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic                 out_last_q;
	logic                 can_load;
	logic                 emit;
	logic                 emit_emb;
	logic                 retire;
	logic                 load_s1;

	// Line store: row parity selects the half, column the entry.
	assign addr = AW'(q_col) + (q_row[0] ? AW'(MAX_WIDTH) : AW'(0));

	erf_ram #(
		.WIDTH(PIX_W),
		.DEPTH(2 * MAX_WIDTH)
	) u_row_store (
		.clk  (clk),
		.we   (q_pop),
		.waddr(addr),
		.wdata(q_pix),
		.re   (q_pop),
		.raddr(addr),
		.rdata(old_word)
	);

	// Diagonal difference against the word read two items earlier.
	assign emb_word = {emb_chan(pix_s1[23:16], delay2_q[23:16]),
	                   emb_chan(pix_s1[15:8],  delay2_q[15:8]),
	                   emb_chan(pix_s1[7:0],   delay2_q[7:0])};

	// Result sequencing: interior result first, then the pass-through.
	assign can_load = !out_valid_q || pop;
	assign emit_emb = flags_s1.emb && !phase_s1;
	assign emit     = valid_s1 && (emit_emb || flags_s1.border) && can_load;
	assign retire   = valid_s1 && ((!flags_s1.emb && !flags_s1.border) ||
	                  (emit && !(emit_emb && flags_s1.border)));
	assign load_s1  = !valid_s1 || retire;
	assign q_pop    = load_s1 && !q_empty;

	// Stage one control and delay line of store words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_s1 <= 1'b0;
			delay1_q <= '0;
			delay2_q <= '0;
		end else begin
			if (retire) begin
				delay2_q <= delay1_q;
				delay1_q <= old_word;
			end
			if (load_s1) begin
				valid_s1 <= !q_empty;
				phase_s1 <= 1'b0;
			end else if (emit) begin
				phase_s1 <= 1'b1;
			end
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_s1   <= q_pix;
			row_s1   <= q_row;
			col_s1   <= q_col;
			flags_s1 <= q_flags;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_load) begin
			out_valid_q <= emit;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (emit_emb) begin
				out_pix_q  <= emb_word;
				out_row_q  <= row_s1 - 1'b1;
				out_col_q  <= OUT_COL_W'(col_s1 - 1'b1);
				out_last_q <= !flags_s1.border;
			end else begin
				out_pix_q  <= pix_s1;
				out_row_q  <= row_s1;
				out_col_q  <= OUT_COL_W'(col_s1);
				out_last_q <= 1'b1;
			end
		end
	end

	assign empty    = !out_valid_q;
	assign res_pix  = out_pix_q;
	assign res_row  = out_row_q;
	assign res_col  = out_col_q;
	assign res_last = out_last_q;

endmodule

>>> sv/emboss_relief_filter.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------
// pixel in | push / full          | in_blue, in_green, in_red
// result   | empty / pop          | out_blue, out_green, out_red, out_row,
//          |                      | out_col, last_of_run
// config   | cfg_we               | cfg_index, cfg_data
//
// One pixel is taken per clock while the item queue is not full; a pixel that
// yields both an interior and a border result holds the back stage while both
// are emitted, which the four-entry item queue absorbs. A result passes
// through the item queue, stage one and the output register to the ports.
// Reset clears the raster position, queue, stage valids and output register;
// the line store holds no reset value. Either side may stall freely.
module emboss_relief_filter import erf_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int QW = FLAGS_W + PIX_W + ROW_W + CW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [CHAN_W-1:0]     in_blue,
	input  logic [CHAN_W-1:0]     in_green,
	input  logic [CHAN_W-1:0]     in_red,
	output logic                  empty,
	input  logic                  pop,
	output logic [CHAN_W-1:0]     out_blue,
	output logic [CHAN_W-1:0]     out_green,
	output logic [CHAN_W-1:0]     out_red,
	output logic [ROW_W-1:0]      out_row,
	output logic [OUT_COL_W-1:0]  out_col,
	output logic                  last_of_run,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic               accept;
	logic [ROW_W-1:0]   f_row;
	logic [CW-1:0]      f_col;
	flags_t             f_flags;
	logic [QW-1:0]      q_wdata;
	logic [QW-1:0]      q_rdata;
	logic               q_empty;
	logic               q_pop;
	flags_t             q_flags;
	logic [PIX_W-1:0]   q_pix;
	logic [ROW_W-1:0]   q_row;
	logic [CW-1:0]      q_col;
	logic [PIX_W-1:0]   res_pix;

	assign accept = push && !full;

	// Front: raster position and classification.
	erf_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.row      (f_row),
		.col      (f_col),
		.flags    (f_flags)
	);

	// Queue of classified items.
	assign q_wdata = {f_flags, in_red, in_green, in_blue, f_row, f_col};

	erf_fifo #(
		.WIDTH(QW),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata (q_wdata),
		.full  (full),
		.rd    (q_pop),
		.rdata (q_rdata),
		.empty (q_empty)
	);

	assign {q_flags, q_pix, q_row, q_col} = q_rdata;

	// Back: line store, emboss and result delivery.
	erf_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.q_pix   (q_pix),
		.q_row   (q_row),
		.q_col   (q_col),
		.q_flags (q_flags),
		.empty   (empty),
		.pop     (pop),
		.res_pix (res_pix),
		.res_row (out_row),
		.res_col (out_col),
		.res_last(last_of_run)
	);

	assign out_blue  = res_pix[7:0];
	assign out_green = res_pix[15:8];
	assign out_red   = res_pix[23:16];

endmodule

>>> dv/emboss_relief_filter_tb.sv
`timescale 1ns / 100ps

module emboss_relief_filter_tb;
	import erf_pkg::*;

	// One result pixel as it leaves the block.
	typedef struct packed {
		logic [CHAN_W-1:0]    blue;
		logic [CHAN_W-1:0]    green;
		logic [CHAN_W-1:0]    red;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] col;
		logic                 is_last;
	} relief_pixel_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [CHAN_W-1:0]     in_blue = '0;
	logic [CHAN_W-1:0]     in_green = '0;
	logic [CHAN_W-1:0]     in_red = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [CHAN_W-1:0]     out_blue;
	logic [CHAN_W-1:0]     out_green;
	logic [CHAN_W-1:0]     out_red;
	logic [ROW_W-1:0]      out_row;
	logic [OUT_COL_W-1:0]  out_col;
	logic                  last_of_run;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Model state of the filter.
	logic [PIX_W-1:0]        line_mem [2*DEF_MAX_WIDTH];
	int unsigned             row_pos = 0;
	int unsigned             col_pos = 0;
	logic [WIDTH_REG_W-1:0]  width_setting = WIDTH_RESET;
	logic [HEIGHT_REG_W-1:0] height_setting = HEIGHT_RESET;
	logic [PIX_W-1:0]        diag_near = '0;
	logic [PIX_W-1:0]        diag_far = '0;

	// Result pixels predicted but not yet seen.
	relief_pixel_t pending_pixels[$];
	relief_pixel_t want_pixel;
	relief_pixel_t seen_pixel;
	logic          seen_pop = 1'b0;
	logic          seen_empty = 1'b1;
	int unsigned   error_count = 0;
	bit            idle_bursts = 1'b1;
	int unsigned   pop_hold = 0;

	emboss_relief_filter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_blue    (in_blue),
		.in_green   (in_green),
		.in_red     (in_red),
		.empty      (empty),
		.pop        (pop),
		.out_blue   (out_blue),
		.out_green  (out_green),
		.out_red    (out_red),
		.out_row    (out_row),
		.out_col    (out_col),
		.last_of_run(last_of_run),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always #6 clk = ~clk;

	// Width and height as the filter uses them, after clamping.
	function automatic int unsigned eff_width();
		if (width_setting == 0) begin
			return 1;
		end
		return (width_setting > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_setting;
	endfunction

	function automatic int unsigned eff_height();
		if (height_setting == 0) begin
			return 1;
		end
		return (height_setting > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_setting;
	endfunction

	// One channel of the relief: new minus old plus the offset, saturated.
	function automatic logic [CHAN_W-1:0] relief_chan(input logic [CHAN_W-1:0] now_c,
	                                                  input logic [CHAN_W-1:0] old_c);
		int v;
		v = int'(now_c) - int'(old_c) + int'(EMB_OFFSET);
		if (v < 0) begin
			v = 0;
		end else if (v > 255) begin
			v = 255;
		end
		return CHAN_W'(v);
	endfunction

	// Advances the model by one accepted pixel and queues what it yields.
	function automatic void predict_relief(input logic [PIX_W-1:0] pix);
		int unsigned   w;
		int unsigned   h;
		int unsigned   idx;
		logic [PIX_W-1:0] old_word;
		logic          interior;
		logic          border;
		relief_pixel_t res;
		w = eff_width();
		h = eff_height();
		old_word = '0;
		idx = (row_pos % 2) * DEF_MAX_WIDTH + col_pos;
		if (col_pos < DEF_MAX_WIDTH) begin
			old_word = line_mem[idx];
			line_mem[idx] = pix;
		end
		interior = (row_pos >= 2) && (col_pos >= 2);
		border = (row_pos == 0) || (col_pos == 0) || (row_pos + 1 >= h) || (col_pos + 1 >= w);

		// The interior result comes first so that results stay in raster order.
		if (interior) begin
			res.blue = relief_chan(pix[CHAN_W-1:0], diag_far[CHAN_W-1:0]);
			res.green = relief_chan(pix[2*CHAN_W-1:CHAN_W], diag_far[2*CHAN_W-1:CHAN_W]);
			res.red = relief_chan(pix[PIX_W-1:2*CHAN_W], diag_far[PIX_W-1:2*CHAN_W]);
			res.row = ROW_W'(row_pos - 1);
			res.col = OUT_COL_W'(col_pos - 1);
			res.is_last = !border;
			pending_pixels.push_back(res);
		end
		diag_far = diag_near;
		diag_near = old_word;
		if (border) begin
			res.blue = pix[CHAN_W-1:0];
			res.green = pix[2*CHAN_W-1:CHAN_W];
			res.red = pix[PIX_W-1:2*CHAN_W];
			res.row = ROW_W'(row_pos);
			res.col = OUT_COL_W'(col_pos);
			res.is_last = 1'b1;
			pending_pixels.push_back(res);
		end

		// Raster position of the next pixel.
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endfunction

	// Channels lean toward the extremes so that both clamps are reached.
	function automatic logic [CHAN_W-1:0] random_chan();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return CHAN_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		return {random_chan(), random_chan(), random_chan()};
	endfunction

	task automatic note_failure(input string msg);
		error_count++;
		if (error_count <= 10) begin
			$display("%s", msg);
		end
	endtask

	// Register write; the model takes the value at the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		if (idx == REG_IMAGE_WIDTH) begin
			width_setting = data[WIDTH_REG_W-1:0];
		end else begin
			height_setting = data;
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Pushes one pixel, with an optional idle burst ahead of it.
	task automatic send_pixel(input logic [PIX_W-1:0] pix);
		if (idle_bursts && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1'b1;
		{in_red, in_green, in_blue} <= pix;
		@(negedge clk);
		while (full) begin
			@(negedge clk);
		end
		@(posedge clk);
		predict_relief(pix);
	endtask

	// Sends random pixels until the raster position wraps to the frame start.
	task automatic send_frame(inout int unsigned count);
		do begin
			send_pixel(random_pixel());
			count++;
		end while (row_pos != 0 || col_pos != 0);
	endtask

	// Waits for every expected result and for the pipeline to settle.
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	// A 3x3 frame whose only interior pixel depends on the two given corners.
	task automatic send_corner_frame(input logic [PIX_W-1:0] top_left,
	                                 input logic [PIX_W-1:0] bottom_right);
		for (int k = 0; k < 9; k++) begin
			send_pixel((k == 0) ? top_left : ((k == 8) ? bottom_right : random_pixel()));
		end
	endtask

	// Part of a row under the reset sizes, then a width and height cut in the middle of the frame.
	task automatic test_reset_defaults();
		int unsigned n;
		n = 0;
		send_pixel('0);
		send_pixel('1);
		send_pixel(24'h00FF00);
		send_pixel(24'hFF00FF);
		send_pixel(random_pixel());
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		send_frame(n);
		wait_idle();
	endtask

	// Both clamp limits, and the exact values where they start.
	task automatic test_clamp_bounds();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
		send_corner_frame(24'h8000FF, 24'h80FF00);
		send_corner_frame(24'h007F80, 24'h01FE00);
		wait_idle();
	endtask

	// Zero sizes count as one; a 2x2 frame is all border.
	task automatic test_degenerate_sizes();
		int unsigned n;
		n = 0;
		write_reg(REG_IMAGE_WIDTH, '0);
		write_reg(REG_IMAGE_HEIGHT, '0);
		repeat (3) send_frame(n);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
		send_frame(n);
		wait_idle();
	endtask

	// Register values above the limits saturate to the widest row and the tallest frame;
	// the tall frame is cut short by a smaller height after a few rows.
	task automatic test_saturated_sizes();
		int unsigned n;
		n = 0;
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2047));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
		send_frame(n);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8191));
		repeat (18) send_pixel(random_pixel());
		wait_idle();
		write_reg(REG_IMAGE_HEIGHT, '0);
		send_frame(n);
		wait_idle();
	endtask

	// Whole frames of random size, some of them cut short by a change of size.
	task automatic test_random_frames(input int unsigned item_goal);
		int unsigned sent;
		int unsigned part;
		int unsigned w_pick;
		int unsigned h_pick;
		sent = 0;
		while (sent < item_goal) begin
			case ($urandom_range(0, 19))
				0: w_pick = 0;
				1, 2: w_pick = $urandom_range(17, 64);
				default: w_pick = $urandom_range(1, 16);
			endcase
			h_pick = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 10);
			write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w_pick));
			write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_pick));
			repeat ($urandom_range(1, 2)) send_frame(sent);

			// A narrower row or another height in the middle of a frame.
			if ($urandom_range(0, 4) == 0) begin
				part = $urandom_range(1, eff_width() * eff_height());
				repeat (part) begin
					send_pixel(random_pixel());
					sent++;
				end
				wait_idle();
				write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'($urandom_range(0, eff_width())));
				if ($urandom_range(0, 1) == 1) begin
					write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'($urandom_range(0, 12)));
				end
				while (row_pos != 0 || col_pos != 0) begin
					send_pixel(random_pixel());
					sent++;
				end
			end
			wait_idle();
		end
	endtask

	// Full rate on both sides.
	task automatic test_steady_stream();
		int unsigned n;
		n = 0;
		idle_bursts = 1'b0;
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(12));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(9));
		repeat (3) send_frame(n);
		wait_idle();
	endtask

	// Result side: pop with random idle bursts.
	always @(posedge clk) begin
		if (pop_hold > 0) begin
			pop_hold <= pop_hold - 1;
			pop <= 1'b0;
		end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
			pop_hold <= $urandom_range(0, 3);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Sample the result side between edges.
	always @(negedge clk) begin
		seen_pop = pop;
		seen_empty = empty;
		seen_pixel = '{out_blue, out_green, out_red, out_row, out_col, last_of_run};
	end

	// Compare each result transaction with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && seen_pop && !seen_empty) begin
			if (pending_pixels.size() == 0) begin
				note_failure($sformatf("unexpected result: b=%0d g=%0d r=%0d row=%0d col=%0d last=%0d",
					seen_pixel.blue, seen_pixel.green, seen_pixel.red, seen_pixel.row,
					seen_pixel.col, seen_pixel.is_last));
			end else begin
				want_pixel = pending_pixels.pop_front();
				if (seen_pixel !== want_pixel) begin
					note_failure($sformatf({"result mismatch: expected b=%0d g=%0d r=%0d row=%0d ",
						"col=%0d last=%0d, got b=%0d g=%0d r=%0d row=%0d col=%0d last=%0d"},
						want_pixel.blue, want_pixel.green, want_pixel.red, want_pixel.row,
						want_pixel.col, want_pixel.is_last, seen_pixel.blue, seen_pixel.green,
						seen_pixel.red, seen_pixel.row, seen_pixel.col, seen_pixel.is_last));
				end
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_clamp_bounds();
		test_degenerate_sizes();
		test_saturated_sizes();
		test_random_frames(500);
		test_steady_stream();
		wait_idle();
		if (error_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog for a stalled handshake.
	initial begin
		#10_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

>>> sim.f
sv/erf_pkg.sv
sv/erf_ram.sv
sv/erf_fifo.sv
sv/erf_front.sv
sv/erf_back.sv
sv/emboss_relief_filter.sv
dv/emboss_relief_filter_tb.sv
